// ----- rtl/core/image_rotate_mirror_crop_addressing_top_assert.svh -----
// assertion macros for the rotate/mirror/crop address generator
// used by image_rotate_mirror_crop_addressing_top; expects clk and rst_n in scope
`ifndef IMAGE_ROTATE_MIRROR_CROP_ADDRESSING_TOP_ASSERT_SVH
`define IMAGE_ROTATE_MIRROR_CROP_ADDRESSING_TOP_ASSERT_SVH

`ifndef SYNTH
// checked on every rising clock edge outside reset
`define IRMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication form, checked outside reset
`define IRMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define IRMC_ASSERT(lbl, prop, msg)
`define IRMC_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/irmc_pkg.sv -----
// shared types and constants of the rotate/mirror/crop address generator
// no dependencies
`default_nettype none

package irmc_pkg;

    // field widths
    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int MODE_W   = 4;
    localparam int STRIDE_W = 15;
    localparam int PIX_W    = 32;
    localparam int OFS_W    = 26;
    localparam int SRC_W    = 14;              // source row / column incl. window offset
    localparam int PROD_W   = SRC_W + STRIDE_W;
    localparam int BPP_SHIFT = 2;              // four bytes per pixel

    // configuration port
    localparam int DATA_W     = 32;
    localparam int REG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CLIP_X        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_Y        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLIP_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MODE          = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd7;

    // mode fields
    localparam int MODE_MIRROR_BIT = 2;
    localparam int MODE_INVERT_BIT = 3;
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [PIX_W-1:0] COLOUR_MASK = 32'h00FF_FFFF;

    // op codes
    localparam logic OP_ADDR  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    typedef struct packed {
        logic [COORD_W-1:0]  clip_x;
        logic [COORD_W-1:0]  clip_y;
        logic [DIM_W-1:0]    clip_width;
        logic [DIM_W-1:0]    clip_height;
        logic [DIM_W-1:0]    source_width;
        logic [DIM_W-1:0]    source_height;
        logic [MODE_W-1:0]   mode;
        logic [STRIDE_W-1:0] line_stride;
    } cfg_t;

    typedef struct packed {
        logic             addr_valid;   // address op inside the output frame
        logic             in_range;
        logic [SRC_W-1:0] src_row;
        logic [SRC_W-1:0] src_col;
        logic [PIX_W-1:0] pixel;
    } q_entry_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/image_rotate_mirror_crop_addressing_top.sv -----
// top level of the rotate/mirror/crop address generator: register file, apb port
// depends on irmc_pkg, irmc_front, irmc_queue, irmc_back and the assertion header
`default_nettype none

`include "image_rotate_mirror_crop_addressing_top_assert.svh"

// One item per clock: an address request (op 0) maps an output position of the
// cropped, rotated and optionally mirrored frame to the byte offset of its source
// pixel, a pixel transfer (op 1) inverts the blue, green and red bytes when the
// invert bit of mode is set. Every accepted item gives exactly one result, shown
// for a single cycle with done high, in accept order. The receiver has no way to
// hold results off, and none is needed: the back end drains the queue every cycle,
// so busy stays low in normal use and start may be held high continuously. Each
// item passes the queue memory, the queue read register, the row-times-stride
// multiplier stage and the final offset add register.
// Positions outside the rotated output frame return in_range low and offset zero.
// Registers sit on the apb port at byte address 4*index and may be rewritten only
// while no item is in flight.

module image_rotate_mirror_crop_addressing_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // item port
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 op,
    input  wire [irmc_pkg::COORD_W-1:0]         out_col,
    input  wire [irmc_pkg::COORD_W-1:0]         out_row,
    input  wire [irmc_pkg::PIX_W-1:0]           pixel_in,
    // result port
    output logic                                done,
    output logic [irmc_pkg::OFS_W-1:0]          src_offset,
    output logic                                in_range,
    output logic [irmc_pkg::PIX_W-1:0]          pixel_out,
    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [irmc_pkg::REG_ADDR_W-1:0]      paddr,
    input  wire [irmc_pkg::DATA_W-1:0]          pwdata,
    output logic [irmc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import irmc_pkg::*;

    cfg_t              cfg_reg;
    logic              cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    q_entry_t          front_entry;
    q_entry_t          q_data;
    q_status_t         q_stat;
    logic              q_valid;
    logic              accept;

    // register write: access phase of an apb write
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[REG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CLIP_X:        cfg_reg.clip_x        <= pwdata[COORD_W-1:0];
                REG_CLIP_Y:        cfg_reg.clip_y        <= pwdata[COORD_W-1:0];
                REG_CLIP_WIDTH:    cfg_reg.clip_width    <= pwdata[DIM_W-1:0];
                REG_CLIP_HEIGHT:   cfg_reg.clip_height   <= pwdata[DIM_W-1:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= pwdata[DIM_W-1:0];
                REG_MODE:          cfg_reg.mode          <= pwdata[MODE_W-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride   <= pwdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback, zero extended
    always_comb
    begin
        unique case (reg_idx)
            REG_CLIP_X:        prdata = DATA_W'(cfg_reg.clip_x);
            REG_CLIP_Y:        prdata = DATA_W'(cfg_reg.clip_y);
            REG_CLIP_WIDTH:    prdata = DATA_W'(cfg_reg.clip_width);
            REG_CLIP_HEIGHT:   prdata = DATA_W'(cfg_reg.clip_height);
            REG_SOURCE_WIDTH:  prdata = DATA_W'(cfg_reg.source_width);
            REG_SOURCE_HEIGHT: prdata = DATA_W'(cfg_reg.source_height);
            REG_MODE:          prdata = DATA_W'(cfg_reg.mode);
            REG_LINE_STRIDE:   prdata = DATA_W'(cfg_reg.line_stride);
            default:           prdata = '0;
        endcase
    end

    // item handshake: the queue only pushes back when it is full
    assign busy   = q_stat.full;
    assign accept = start && !busy;

    irmc_front u_front (
        .cfg      (cfg_reg),
        .op       (op),
        .out_col  (out_col),
        .out_row  (out_row),
        .pixel_in (pixel_in),
        .entry    (front_entry)
    );

    // back end never stalls, so drain whenever something is queued
    irmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_entry),
        .pop       (!q_stat.empty),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .status    (q_stat)
    );

    irmc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .entry       (q_data),
        .line_stride (cfg_reg.line_stride),
        .done        (done),
        .src_offset  (src_offset),
        .in_range    (in_range),
        .pixel_out   (pixel_out)
    );

    // queue holds at most one item since the back drains every cycle
    `IRMC_ASSERT(a_queue_shallow, q_stat.level <= QLVL_W'(1), "queue grew beyond one entry")
    // a result that is out of range carries nothing
    `IRMC_ASSERT_IMP(a_out_of_range_zero, done && !in_range,
        (src_offset == '0) && (pixel_out == '0), "out-of-range result not zero")
    // a pixel result never carries an offset
    `IRMC_ASSERT_IMP(a_pixel_no_offset, done && (pixel_out != '0),
        (src_offset == '0) && in_range, "pixel result with offset or range flag low")

endmodule

`default_nettype wire

// ----- rtl/core/irmc_front.sv -----
// front end: classifies an item and resolves source row/column or the pixel
// depends on irmc_pkg
`default_nettype none

module irmc_front (
    input  wire irmc_pkg::cfg_t                    cfg,
    input  wire                                    op,
    input  wire [irmc_pkg::COORD_W-1:0]            out_col,
    input  wire [irmc_pkg::COORD_W-1:0]            out_row,
    input  wire [irmc_pkg::PIX_W-1:0]              pixel_in,
    output irmc_pkg::q_entry_t                     entry
);
    import irmc_pkg::*;

    logic             empty_clip;
    logic [SRC_W-1:0] cx, cy, cw, ch, ow, oh, col, row;
    logic [SRC_W-1:0] col_fwd, col_rev_c, col_fwd_r, col_rev_r;
    logic [1:0]       rot;
    logic             mir;
    logic             in_frame;
    logic [SRC_W-1:0] srow, scol;

    always_comb
    begin
        empty_clip = (cfg.clip_width == '0) || (cfg.clip_height == '0);
        cx  = empty_clip ? '0 : SRC_W'(cfg.clip_x);
        cy  = empty_clip ? '0 : SRC_W'(cfg.clip_y);
        cw  = empty_clip ? SRC_W'(cfg.source_width)  : SRC_W'(cfg.clip_width);
        ch  = empty_clip ? SRC_W'(cfg.source_height) : SRC_W'(cfg.clip_height);
        rot = cfg.mode[1:0];
        mir = cfg.mode[MODE_MIRROR_BIT];
        ow  = rot[0] ? ch : cw;
        oh  = rot[0] ? cw : ch;
        col = SRC_W'(out_col);
        row = SRC_W'(out_row);
        in_frame = (col < ow) && (row < oh);

        // column candidates, exact whenever the position is in the frame
        col_fwd   = cx + col;
        col_rev_c = cx + cw - SRC_W'(1) - col;
        col_fwd_r = cx + row;
        col_rev_r = cx + cw - SRC_W'(1) - row;

        unique case (rot)
            ROT_0:
            begin
                srow = cy + row;
                scol = mir ? col_rev_c : col_fwd;
            end
            ROT_90:
            begin
                srow = cy + col;
                scol = mir ? col_fwd_r : col_rev_r;
            end
            ROT_180:
            begin
                srow = cy + ch - SRC_W'(1) - row;
                scol = mir ? col_fwd : col_rev_c;
            end
            ROT_270:
            begin
                srow = cy + ch - SRC_W'(1) - col;
                scol = mir ? col_rev_r : col_fwd_r;
            end
            default:
            begin
                srow = '0;
                scol = '0;
            end
        endcase

        if (op == OP_PIXEL)
        begin
            entry.addr_valid = 1'b0;
            entry.in_range   = 1'b1;
            entry.src_row    = '0;
            entry.src_col    = '0;
            entry.pixel      = cfg.mode[MODE_INVERT_BIT] ? (pixel_in ^ COLOUR_MASK) : pixel_in;
        end
        else
        begin
            entry.addr_valid = in_frame;
            entry.in_range   = in_frame;
            entry.src_row    = srow;
            entry.src_col    = scol;
            entry.pixel      = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/irmc_queue.sv -----
// small fifo between front and back, registered read port
// depends on irmc_pkg
`default_nettype none

module irmc_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wire irmc_pkg::q_entry_t push_data,
    input  wire                   pop,
    output logic                  pop_valid,
    output irmc_pkg::q_entry_t    pop_data,
    output irmc_pkg::q_status_t   status
);
    import irmc_pkg::*;

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg, level_next;
    logic              do_push, do_pop;
    logic              valid_reg;
    q_entry_t          data_reg;

    assign status.empty = (level_reg == '0);
    assign status.full  = (level_reg == QLVL_W'(QDEPTH));
    assign status.level = level_reg;

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        level_next = level_reg;
        if (do_push && !do_pop)
            level_next = level_reg + QLVL_W'(1);
        else if (do_pop && !do_push)
            level_next = level_reg - QLVL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
        if (do_pop)
            data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            level_reg <= level_next;
            valid_reg <= do_pop;
        end
    end

    assign pop_valid = valid_reg;
    assign pop_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/irmc_back.sv -----
// back end: row times stride multiply, then offset add and result strobe
// depends on irmc_pkg
`default_nettype none

module irmc_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    input  wire irmc_pkg::q_entry_t        entry,
    input  wire [irmc_pkg::STRIDE_W-1:0]   line_stride,
    output logic                           done,
    output logic [irmc_pkg::OFS_W-1:0]     src_offset,
    output logic                           in_range,
    output logic [irmc_pkg::PIX_W-1:0]     pixel_out
);
    import irmc_pkg::*;

    // multiply stage
    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SRC_W-1:0]  scol_reg;
    logic              addr_valid_reg;
    logic              range_reg;
    logic [PIX_W-1:0]  pix_reg;

    // output stage
    logic              out_valid_reg;
    logic [OFS_W-1:0]  ofs_reg, ofs_next;
    logic              out_range_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    always_comb
    begin
        if (addr_valid_reg)
            ofs_next = prod_reg[OFS_W-1:0]
                     + OFS_W'({scol_reg, {BPP_SHIFT{1'b0}}});
        else
            ofs_next = '0;
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= PROD_W'(entry.src_row) * PROD_W'(line_stride);
        scol_reg       <= entry.src_col;
        addr_valid_reg <= entry.addr_valid;
        range_reg      <= entry.in_range;
        pix_reg        <= entry.pixel;
        ofs_reg        <= ofs_next;
        out_range_reg  <= range_reg;
        out_pix_reg    <= pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    assign done       = out_valid_reg;
    assign src_offset = ofs_reg;
    assign in_range   = out_range_reg;
    assign pixel_out  = out_pix_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_image_rotate_mirror_crop_addressing_top.sv -----
// self-checking testbench for image_rotate_mirror_crop_addressing_top
// directed table then randomized phases, each result checked against a typed expectation or an in-bench predictor
// depends on irmc_pkg and the rtl of the address generator
`default_nettype none

module tb_image_rotate_mirror_crop_addressing_top;

    timeunit 1ns;
    timeprecision 1ps;

    import irmc_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // settle time after the final drain, with margin over the result pipeline
    localparam int RESULT_LATENCY = 8;
    localparam int RANDOM_PHASES  = 10;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int REPORT_MAX     = 10;

    // one result transfer as seen on the output ports
    typedef struct packed {
        logic [OFS_W-1:0] ofs;
        logic             inr;
        logic [PIX_W-1:0] pix;
    } result_t;

    // one row of the directed table: either a register write or an item transfer
    typedef struct packed {
        logic                 is_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    val;
        logic                 op;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [PIX_W-1:0]     pix;
        logic                 fixed;    // expected result typed into the row
        result_t              want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [COORD_W-1:0]    out_col;
    logic [COORD_W-1:0]    out_row;
    logic [PIX_W-1:0]      pixel_in;
    logic                  done;
    logic [OFS_W-1:0]      src_offset;
    logic                  in_range;
    logic [PIX_W-1:0]      pixel_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // bench copy of the register file, updated on every completed apb write
    cfg_t    cfg_model;
    // predicted results in accept order, oldest at the front
    result_t pending_results[$];
    step_t   directed_steps[$];

    int mismatches   = 0;
    int n_items      = 0;
    int n_addr       = 0;
    int n_pixel      = 0;
    int n_hits       = 0;
    int n_misses     = 0;
    int n_results    = 0;
    int n_reg_writes = 0;
    int stall_cycles = 0;

    image_rotate_mirror_crop_addressing_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .out_col    (out_col),
        .out_row    (out_row),
        .pixel_in   (pixel_in),
        .done       (done),
        .src_offset (src_offset),
        .in_range   (in_range),
        .pixel_out  (pixel_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // rotated output frame size {width, height}; an empty crop window means the whole source
    function automatic logic [2*DIM_W-1:0] out_dims(cfg_t c);
        logic             win_empty;
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        win_empty = (c.clip_width == '0) || (c.clip_height == '0);
        cw = win_empty ? c.source_width  : c.clip_width;
        ch = win_empty ? c.source_height : c.clip_height;
        // quarter turns swap width and height
        return c.mode[0] ? {ch, cw} : {cw, ch};
    endfunction

    function automatic result_t predict_result(cfg_t c, logic op_i, logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row, logic [PIX_W-1:0] pix);
        result_t            r;
        logic               win_empty;
        logic               mir;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [DIM_W-1:0]   cw;
        logic [DIM_W-1:0]   ch;
        logic [DIM_W-1:0]   ow;
        logic [DIM_W-1:0]   oh;
        logic [SRC_W-1:0]   srow;
        logic [SRC_W-1:0]   scol;
        logic [PROD_W:0]    prod;
        r = '0;
        if (op_i == OP_PIXEL)
        begin
            // alpha byte passes through untouched
            r.inr = 1'b1;
            r.pix = c.mode[MODE_INVERT_BIT] ? (pix ^ COLOUR_MASK) : pix;
            return r;
        end
        win_empty = (c.clip_width == '0) || (c.clip_height == '0);
        cx = win_empty ? '0 : c.clip_x;
        cy = win_empty ? '0 : c.clip_y;
        cw = win_empty ? c.source_width  : c.clip_width;
        ch = win_empty ? c.source_height : c.clip_height;
        {ow, oh} = out_dims(c);
        // outside the output frame: all fields stay zero
        if (col >= ow || row >= oh)
            return r;
        mir = c.mode[MODE_MIRROR_BIT];
        case (c.mode[1:0])
            ROT_0:
            begin
                srow = cy + row;
                scol = mir ? (cx + cw - 1'b1 - col) : (cx + col);
            end
            ROT_90:
            begin
                srow = cy + col;
                scol = mir ? (cx + row) : (cx + cw - 1'b1 - row);
            end
            ROT_180:
            begin
                srow = cy + ch - 1'b1 - row;
                scol = mir ? (cx + col) : (cx + cw - 1'b1 - col);
            end
            default:
            begin
                srow = cy + ch - 1'b1 - col;
                scol = mir ? (cx + cw - 1'b1 - row) : (cx + row);
            end
        endcase
        // no bounds check against the source, the offset simply wraps
        prod  = srow * c.line_stride + (scol << BPP_SHIFT);
        r.ofs = prod[OFS_W-1:0];
        r.inr = 1'b1;
        return r;
    endfunction

    function automatic result_t result_of(logic [OFS_W-1:0] o, logic i, logic [PIX_W-1:0] p);
        result_t r;
        r.ofs = o;
        r.inr = i;
        r.pix = p;
        return r;
    endfunction

    function automatic step_t cfg_step(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        step_t s;
        s = '0;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.val     = val;
        return s;
    endfunction

    function automatic step_t item_step(logic op_i, logic [COORD_W-1:0] col,
                                        logic [COORD_W-1:0] row, logic [PIX_W-1:0] pix,
                                        logic fixed, result_t want);
        step_t s;
        s = '0;
        s.op    = op_i;
        s.col   = col;
        s.row   = row;
        s.pix   = pix;
        s.fixed = fixed;
        s.want  = want;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // random picks, biased toward edges of the frame and small windows
    // ------------------------------------------------------------------

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(11))
            0:       return '0;
            1:       return DIM_W'(4096);
            2:       return DIM_W'(1);
            3:       return DIM_W'($urandom_range(8191));
            4, 5:    return DIM_W'($urandom_range(4096, 1));
            default: return DIM_W'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_origin();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [STRIDE_W-1:0] pick_stride();
        case ($urandom_range(4))
            0:       return '0;
            1:       return STRIDE_W'(16384);
            2:       return '1;
            default: return STRIDE_W'($urandom);
        endcase
    endfunction

    // mostly inside [0, lim), sometimes exactly on the edge or anywhere in the field
    function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] lim);
        int unsigned top;
        top = (lim > 4096) ? 4096 : lim;
        case ($urandom_range(9))
            0, 1:    return COORD_W'($urandom);
            2:       return COORD_W'(lim);
            default: return (top == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(top - 1));
        endcase
    endfunction

    // random garbage above the register width, which the block has to drop
    function automatic logic [DATA_W-1:0] with_noise(logic [DATA_W-1:0] v);
        return $urandom_range(1) ? (v | ($urandom & 32'hFFFF_0000)) : v;
    endfunction

    // ------------------------------------------------------------------
    // drivers: inputs change on the falling edge, handshakes seen on the rising edge
    // ------------------------------------------------------------------

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_CLIP_X:        cfg_model.clip_x        = data[COORD_W-1:0];
            REG_CLIP_Y:        cfg_model.clip_y        = data[COORD_W-1:0];
            REG_CLIP_WIDTH:    cfg_model.clip_width    = data[DIM_W-1:0];
            REG_CLIP_HEIGHT:   cfg_model.clip_height   = data[DIM_W-1:0];
            REG_SOURCE_WIDTH:  cfg_model.source_width  = data[DIM_W-1:0];
            REG_SOURCE_HEIGHT: cfg_model.source_height = data[DIM_W-1:0];
            REG_MODE:          cfg_model.mode          = data[MODE_W-1:0];
            default:           cfg_model.line_stride   = data[STRIDE_W-1:0];
        endcase
        n_reg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop issuing and let every predicted result come back before touching registers
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one item transfer, preceded by a random pause when gap_pct asks for it;
    // start stays high across back-to-back items
    task automatic drive_item(logic op_i, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic [PIX_W-1:0] pix, logic fixed, result_t want, int gap_pct);
        int      gap;
        result_t r;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(6, 1);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start    = 1'b1;
        op       = op_i;
        out_col  = col;
        out_row  = row;
        pixel_in = pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted on this edge: predict with the registers as they are now
        r = fixed ? want : predict_result(cfg_model, op_i, col, row, pix);
        pending_results.push_back(r);
        n_items++;
        if (op_i == OP_PIXEL)
            n_pixel++;
        else
        begin
            n_addr++;
            if (r.inr)
                n_hits++;
            else
                n_misses++;
        end
    endtask

    // every register written each phase; first phase all ones, second all zeros
    task automatic program_phase(int ph);
        logic [DATA_W-1:0] v [8];
        if (ph == 0)
        begin
            foreach (v[i])
                v[i] = '1;
        end
        else if (ph == 1)
        begin
            foreach (v[i])
                v[i] = '0;
        end
        else
        begin
            v[REG_CLIP_X]        = with_noise(DATA_W'(pick_origin()));
            v[REG_CLIP_Y]        = with_noise(DATA_W'(pick_origin()));
            v[REG_CLIP_WIDTH]    = with_noise(DATA_W'(pick_dim()));
            v[REG_CLIP_HEIGHT]   = with_noise(DATA_W'(pick_dim()));
            v[REG_SOURCE_WIDTH]  = with_noise(DATA_W'(pick_dim()));
            v[REG_SOURCE_HEIGHT] = with_noise(DATA_W'(pick_dim()));
            // rotation and mirror walk through all combinations over the phases
            v[REG_MODE]          = with_noise(DATA_W'({1'($urandom_range(1)), 3'(ph)}));
            v[REG_LINE_STRIDE]   = with_noise(DATA_W'(pick_stride()));
        end
        foreach (v[i])
            write_reg(REG_IDX_W'(i), v[i]);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
    endtask

    // done is a one-cycle strobe; sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
                note_mismatch("unexpected result transfer", '0, DATA_W'(src_offset));
            else
            begin
                want = pending_results.pop_front();
                if (src_offset !== want.ofs)
                    note_mismatch("src_offset", DATA_W'(want.ofs), DATA_W'(src_offset));
                if (in_range !== want.inr)
                    note_mismatch("in_range", DATA_W'(want.inr), DATA_W'(in_range));
                if (pixel_out !== want.pix)
                    note_mismatch("pixel_out", want.pix, pixel_out);
            end
        end
    end

    // watchdog: cycles with no item, result or register transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        step_t s;
        rst_n    = 1'b0;
        start    = 1'b0;
        op       = OP_ADDR;
        out_col  = '0;
        out_row  = '0;
        pixel_in = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_model = '0;

        // directed table
        // after reset every register is zero: empty frame, no inversion
        directed_steps.push_back(item_step(OP_ADDR, '0, '0, 32'hDEAD_BEEF, 1'b1,
                                           result_of('0, 1'b0, '0)));
        directed_steps.push_back(item_step(OP_PIXEL, '1, '1, 32'h1234_5678, 1'b1,
                                           result_of('0, 1'b1, 32'h1234_5678)));
        // colour inversion keeps alpha
        directed_steps.push_back(cfg_step(REG_MODE, DATA_W'(1 << MODE_INVERT_BIT)));
        directed_steps.push_back(item_step(OP_PIXEL, '0, '0, 32'hFFFF_FFFF, 1'b1,
                                           result_of('0, 1'b1, 32'hFF00_0000)));
        directed_steps.push_back(item_step(OP_PIXEL, '1, '1, 32'h0000_0000, 1'b1,
                                           result_of('0, 1'b1, 32'h00FF_FFFF)));
        // full 4096 x 4096 source, largest offset that still fits
        directed_steps.push_back(cfg_step(REG_SOURCE_WIDTH, DATA_W'(4096)));
        directed_steps.push_back(cfg_step(REG_SOURCE_HEIGHT, DATA_W'(4096)));
        directed_steps.push_back(cfg_step(REG_LINE_STRIDE, DATA_W'(16384)));
        directed_steps.push_back(cfg_step(REG_MODE, DATA_W'(ROT_0)));
        directed_steps.push_back(item_step(OP_ADDR, '1, '1, '0, 1'b1,
                                           result_of(26'd67108860, 1'b1, '0)));
        directed_steps.push_back(item_step(OP_ADDR, '0, '0, '1, 1'b1,
                                           result_of('0, 1'b1, '0)));
        // crop height still zero, so the window is still the whole source
        directed_steps.push_back(cfg_step(REG_CLIP_WIDTH, DATA_W'(5)));
        directed_steps.push_back(item_step(OP_ADDR, '1, 12'd7, '0, 1'b0, '0));
        // 5 x 3 window at (10, 20), positions on and just past each edge
        directed_steps.push_back(cfg_step(REG_CLIP_X, DATA_W'(10)));
        directed_steps.push_back(cfg_step(REG_CLIP_Y, DATA_W'(20)));
        directed_steps.push_back(cfg_step(REG_CLIP_HEIGHT, DATA_W'(3)));
        directed_steps.push_back(cfg_step(REG_LINE_STRIDE, DATA_W'(100)));
        directed_steps.push_back(item_step(OP_ADDR, 12'd4, 12'd2, '0, 1'b0, '0));
        directed_steps.push_back(item_step(OP_ADDR, 12'd5, 12'd0, '0, 1'b1,
                                           result_of('0, 1'b0, '0)));
        directed_steps.push_back(item_step(OP_ADDR, 12'd0, 12'd3, '0, 1'b1,
                                           result_of('0, 1'b0, '0)));
        // every rotation with and without mirror; quarter turns get the far corner too
        for (int m = 1; m < 8; m++)
        begin
            directed_steps.push_back(cfg_step(REG_MODE, DATA_W'(m)));
            directed_steps.push_back(item_step(OP_ADDR, '0, '0, '0, 1'b0, '0));
            if (m % 2 == 1)
                directed_steps.push_back(item_step(OP_ADDR, 12'd2, 12'd4, '0, 1'b0, '0));
        end
        // window running past the source and the widest stride: offset wraps
        directed_steps.push_back(cfg_step(REG_CLIP_X, DATA_W'(4095)));
        directed_steps.push_back(cfg_step(REG_CLIP_Y, DATA_W'(4095)));
        directed_steps.push_back(cfg_step(REG_CLIP_WIDTH, DATA_W'(4096)));
        directed_steps.push_back(cfg_step(REG_CLIP_HEIGHT, DATA_W'(4096)));
        directed_steps.push_back(cfg_step(REG_LINE_STRIDE, DATA_W'(32767)));
        directed_steps.push_back(cfg_step(REG_MODE, DATA_W'(ROT_180)));
        directed_steps.push_back(item_step(OP_ADDR, '0, '0, '0, 1'b0, '0));
        // empty crop falling back to a zero-width source: nothing is in the frame
        directed_steps.push_back(cfg_step(REG_CLIP_HEIGHT, '0));
        directed_steps.push_back(cfg_step(REG_SOURCE_WIDTH, '0));
        directed_steps.push_back(item_step(OP_ADDR, '0, '0, '0, 1'b1,
                                           result_of('0, 1'b0, '0)));

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            if (s.is_cfg)
            begin
                // registers only change with nothing in flight
                wait_idle();
                write_reg(s.reg_idx, s.val);
            end
            else
                drive_item(s.op, s.col, s.row, s.pix, s.fixed, s.want, 0);
        end

        // random phases, sender pacing cycles through a pause before none, 70 and 27 percent of items
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            int gap_pct;
            logic [DIM_W-1:0] ow;
            logic [DIM_W-1:0] oh;
            case (ph % 3)
                0:       gap_pct = 0;
                1:       gap_pct = 70;
                default: gap_pct = 27;
            endcase
            wait_idle();
            program_phase(ph);
            {ow, oh} = out_dims(cfg_model);
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(3) == 0)
                    drive_item(OP_PIXEL, COORD_W'($urandom), COORD_W'($urandom), $urandom,
                               1'b0, '0, gap_pct);
                else
                    drive_item(OP_ADDR, pick_coord(ow), pick_coord(oh), $urandom,
                               1'b0, '0, gap_pct);
            end
        end

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (RESULT_LATENCY)
            @(posedge clk);

        $display("%0d item transfers (%0d address, %0d pixel), %0d results, %0d mismatches",
                 n_items, n_addr, n_pixel, n_results, mismatches);
        $display("%0d addresses inside the frame, %0d outside, %0d register writes",
                 n_hits, n_misses, n_reg_writes);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- image_rotate_mirror_crop_addressing_top.f -----
+incdir+rtl/core
rtl/core/irmc_pkg.sv
rtl/core/irmc_front.sv
rtl/core/irmc_queue.sv
rtl/core/irmc_back.sv
rtl/core/image_rotate_mirror_crop_addressing_top.sv
tb/sv/tb_image_rotate_mirror_crop_addressing_top.sv
